// ----- design/fhaf_pkg.sv -----
// ----------------------------------------------------------------------------
// fhaf_pkg - frame header address filter package
// Shared types and constants for the receive frame header filter.
// ----------------------------------------------------------------------------
package fhaf_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 12;
	localparam int PAN_W    = 16;
	localparam int LADDR_W  = 64;
	localparam int CFG_W    = 64;
	localparam int PADDR_W  = 6;
	localparam int NUM_LANE = LADDR_W / BYTE_W;

	localparam logic [PAN_W-1:0] BCAST16     = 16'hFFFF;
	localparam logic [2:0]       TYPE_BEACON = 3'd0;
	localparam logic [2:0]       TYPE_MAX    = 3'd3;
	localparam logic [1:0]       VER_2       = 2'd2;
	localparam logic [1:0]       VER_3       = 2'd3;
	localparam int               ACK_BIT     = 5;
	localparam int               FCS_BIT     = 4;

	typedef enum logic [2:0] {
		VERDICT_ACCEPT    = 3'd0,
		VERDICT_BAD_LEN   = 3'd1,
		VERDICT_BAD_TYPE  = 3'd2,
		VERDICT_BAD_VER   = 3'd3,
		VERDICT_PAN_REJ   = 3'd4,
		VERDICT_ADDR_REJ  = 3'd5
	} verdict_t;

	typedef enum logic [2:0] {
		REG_PAN_ID     = 3'd0,
		REG_SHORT_ADDR = 3'd1,
		REG_LONG_ADDR  = 3'd2,
		REG_PHY_MODE   = 3'd3,
		REG_MIN_RX     = 3'd4,
		REG_MAX_RX     = 3'd5,
		REG_STROBE     = 3'd6
	} reg_idx_t;

endpackage

// ----- design/fhaf_if.sv -----
// ----------------------------------------------------------------------------
// fhaf_if - frame filter channel interfaces
// Received byte channel and verdict channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fhaf_rx_if;
	import fhaf_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic              frame_start;
	modport source (output valid, frame_byte, frame_start, input ready);
	modport sink (input valid, frame_byte, frame_start, output ready);
endinterface

interface fhaf_res_if;
	import fhaf_pkg::*;
	logic              valid;
	logic              ready;
	logic [2:0]        verdict;
	logic              ack_required;
	logic [BYTE_W-1:0] seq_number;
	logic              fcs_is_32;
	logic [LEN_W-1:0]  remaining_bytes;
	modport source (output valid, verdict, ack_required, seq_number, fcs_is_32,
		remaining_bytes, input ready);
	modport sink (input valid, verdict, ack_required, seq_number, fcs_is_32,
		remaining_bytes, output ready);
endinterface

// ----- design/frame_header_address_filter_top.sv -----
// ----------------------------------------------------------------------------
// frame_header_address_filter_top - receive frame header and address filter
// Parses PHR, frame control, sequence number and destination PAN/address
// one byte per word and issues at most one verdict word per frame.
// A verdict word is registered: valid in the cycle after its deciding byte.
// Throughput: one byte per cycle unless a verdict word waits undrained; parse
// state and result register update at the same edge; it frees as it drains.
// Reset: arst_n clears the parser to idle and loads the register defaults.
// ----------------------------------------------------------------------------
module frame_header_address_filter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	fhaf_rx_if.sink                        rx,
	fhaf_res_if.source                     res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fhaf_pkg::PADDR_W-1:0]   paddr,
	input  logic [fhaf_pkg::CFG_W-1:0]     pwdata,
	output logic [fhaf_pkg::CFG_W-1:0]     prdata,
	output logic                           pready
);
	import fhaf_pkg::*;

	// configuration registers
	logic [PAN_W-1:0]   pan_id_q;
	logic [PAN_W-1:0]   short_addr_q;
	logic [LADDR_W-1:0] long_addr_q;
	logic               phy_mode_q;
	logic [LEN_W-1:0]   min_rx_q;
	logic [LEN_W-1:0]   max_rx_q;
	logic [2:0]         strobe_q;

	// parse state
	logic [LEN_W-1:0]   pos_q, pos_n;
	logic [LEN_W-1:0]   tot_q, tot_n;
	logic [BYTE_W-1:0]  phr_q, phr_n;
	logic [BYTE_W-1:0]  cl_q, cl_n;
	logic [BYTE_W-1:0]  ch_q, ch_n;
	logic [BYTE_W-1:0]  seq_q, seq_n;
	logic [PAN_W-1:0]   pan_q, pan_n;
	logic [LADDR_W-1:0] addr_q, addr_n;
	logic               decided_q, decided_n;

	// result register
	logic               res_valid_q;
	verdict_t           res_verdict_q;
	logic               res_ack_q;
	logic [BYTE_W-1:0]  res_seq_q;
	logic               res_fcs_q;
	logic [LEN_W-1:0]   res_rem_q;

	logic               cfg_wr;
	reg_idx_t           cfg_idx;
	logic               rx_acc;
	logic               active;
	logic               emit;
	verdict_t           vd;
	logic               supp_n;
	logic               parsed;
	logic               seq_ok;
	logic               emit_ack;
	logic [BYTE_W-1:0]  emit_seq;
	logic               emit_fcs;
	logic [LEN_W-1:0]   emit_rem;
	logic [LEN_W-1:0]   hdr;
	logic [LEN_W-1:0]   pstart;
	logic [LEN_W-1:0]   kk;
	logic [LEN_W-1:0]   jj;
	logic [10:0]        len;
	logic [LEN_W-1:0]   tot_c;

	// ---------------- APB register port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_id_q     <= BCAST16;
			short_addr_q <= 16'hFFFE;
			long_addr_q  <= '0;
			phy_mode_q   <= 1'b0;
			min_rx_q     <= 12'd5;
			max_rx_q     <= 12'd128;
			strobe_q     <= 3'd4;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PAN_ID:     pan_id_q     <= pwdata[PAN_W-1:0];
				REG_SHORT_ADDR: short_addr_q <= pwdata[PAN_W-1:0];
				REG_LONG_ADDR:  long_addr_q  <= pwdata[LADDR_W-1:0];
				REG_PHY_MODE:   phy_mode_q   <= pwdata[0];
				REG_MIN_RX:     min_rx_q     <= pwdata[LEN_W-1:0];
				REG_MAX_RX:     max_rx_q     <= pwdata[LEN_W-1:0];
				REG_STROBE:     strobe_q     <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_PAN_ID:     prdata = CFG_W'(pan_id_q);
			REG_SHORT_ADDR: prdata = CFG_W'(short_addr_q);
			REG_LONG_ADDR:  prdata = long_addr_q;
			REG_PHY_MODE:   prdata = CFG_W'(phy_mode_q);
			REG_MIN_RX:     prdata = CFG_W'(min_rx_q);
			REG_MAX_RX:     prdata = CFG_W'(max_rx_q);
			REG_STROBE:     prdata = CFG_W'(strobe_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- byte parser ----------------
	assign rx.ready = !res_valid_q || res.ready;
	assign rx_acc   = rx.valid && rx.ready;
	assign active   = rx.frame_start || !decided_q;
	assign hdr      = phy_mode_q ? 12'd2 : 12'd1;

	always_comb begin
		if (rx.frame_start) begin
			pos_n = '0; tot_n = '0; phr_n = '0; cl_n = '0; ch_n = '0;
			seq_n = '0; pan_n = '0; addr_n = '0; decided_n = 1'b0;
		end else begin
			pos_n = pos_q; tot_n = tot_q; phr_n = phr_q; cl_n = cl_q; ch_n = ch_q;
			seq_n = seq_q; pan_n = pan_q; addr_n = addr_q; decided_n = decided_q;
		end
		emit   = 1'b0;
		vd     = VERDICT_ACCEPT;
		len    = '0;
		tot_c  = '0;
		pstart = '0;
		kk     = '0;
		jj     = '0;
		supp_n = 1'b0;

		if (pos_n == '0 || (pos_n < hdr)) begin
			if (pos_n == '0) begin
				phr_n = rx.frame_byte;
				len   = {4'd0, rx.frame_byte[6:0]};
			end else begin
				len = {phr_n[2:0], rx.frame_byte};
			end
			tot_c = hdr + LEN_W'(len);
			if (pos_n != '0 || !phy_mode_q) begin
				tot_n = tot_c;
				if (len == '0 || tot_c < min_rx_q || tot_c > max_rx_q) begin
					emit = 1'b1;
					vd   = VERDICT_BAD_LEN;
				end
			end
		end else if (pos_n == hdr) begin
			cl_n = rx.frame_byte;
			if (rx.frame_byte[2:0] > TYPE_MAX && rx.frame_byte[2:0] != strobe_q) begin
				emit = 1'b1;
				vd   = VERDICT_BAD_TYPE;
			end
		end else if (pos_n == hdr + 12'd1) begin
			ch_n   = rx.frame_byte;
			supp_n = (ch_n[5:4] == VER_2) && ch_n[0];
			if (ch_n[5:4] == VER_3) begin
				emit = 1'b1;
				vd   = VERDICT_BAD_VER;
			end else if (supp_n && !ch_n[3]) begin
				emit = 1'b1;
				vd   = VERDICT_ACCEPT;
			end
		end else begin
			supp_n = (ch_n[5:4] == VER_2) && ch_n[0];
			if (!supp_n && pos_n == hdr + 12'd2) begin
				seq_n = rx.frame_byte;
				if (!ch_n[3]) begin
					emit = 1'b1;
					vd   = VERDICT_ACCEPT;
				end
			end else begin
				pstart = hdr + 12'd2 + (supp_n ? 12'd0 : 12'd1);
				kk     = pos_n - pstart;
				jj     = kk - 12'd2;
				if (pos_n < pstart) begin
					emit = 1'b0;
				end else if (kk == 12'd0) begin
					pan_n = {8'd0, rx.frame_byte};
				end else if (kk == 12'd1) begin
					pan_n = pan_n | {rx.frame_byte, 8'd0};
					if (pan_n == BCAST16) begin
						if (cl_n[2:0] != TYPE_BEACON) begin
							emit = 1'b1;
							vd   = VERDICT_ACCEPT;
						end
					end else if (pan_id_q != BCAST16 && pan_n != pan_id_q) begin
						emit = 1'b1;
						vd   = VERDICT_PAN_REJ;
					end
				end else begin
					for (int i = 0; i < NUM_LANE; i++) begin
						if (jj == LEN_W'(i))
							addr_n[BYTE_W*i +: BYTE_W] = addr_n[BYTE_W*i +: BYTE_W] | rx.frame_byte;
					end
					if (pan_n == BCAST16) begin
						if (jj == 12'd1) begin
							emit = 1'b1;
							vd   = (pan_id_q != BCAST16 && pan_id_q != addr_n[PAN_W-1:0])
								? VERDICT_PAN_REJ : VERDICT_ACCEPT;
						end
					end else if (ch_n[3:2] == 2'd2) begin
						if (jj == 12'd1) begin
							emit = 1'b1;
							vd   = (addr_n[PAN_W-1:0] == BCAST16 ||
								addr_n[PAN_W-1:0] == short_addr_q)
								? VERDICT_ACCEPT : VERDICT_ADDR_REJ;
						end
					end else if (jj == 12'd7) begin
						emit = 1'b1;
						vd   = (addr_n == long_addr_q) ? VERDICT_ACCEPT : VERDICT_ADDR_REJ;
					end
				end
			end
		end

		pos_n = pos_n + 12'd1;
		if (emit)
			decided_n = 1'b1;
	end

	// result fields from the updated state
	always_comb begin
		parsed   = (vd == VERDICT_ACCEPT) || (vd == VERDICT_PAN_REJ) ||
			(vd == VERDICT_ADDR_REJ);
		seq_ok   = parsed && !((ch_n[5:4] == VER_2) && ch_n[0]);
		emit_ack = seq_ok & cl_n[ACK_BIT];
		emit_seq = seq_ok ? seq_n : '0;
		emit_fcs = phy_mode_q & ~phr_n[FCS_BIT];
		emit_rem = (parsed && tot_n >= min_rx_q) ? (tot_n - min_rx_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			tot_q     <= '0;
			phr_q     <= '0;
			cl_q      <= '0;
			ch_q      <= '0;
			seq_q     <= '0;
			pan_q     <= '0;
			addr_q    <= '0;
			decided_q <= 1'b1;
		end else if (rx_acc && active) begin
			pos_q     <= pos_n;
			tot_q     <= tot_n;
			phr_q     <= phr_n;
			cl_q      <= cl_n;
			ch_q      <= ch_n;
			seq_q     <= seq_n;
			pan_q     <= pan_n;
			addr_q    <= addr_n;
			decided_q <= decided_n;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rx_acc && active && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_acc && active && emit) begin
			res_verdict_q <= vd;
			res_ack_q     <= emit_ack;
			res_seq_q     <= emit_seq;
			res_fcs_q     <= emit_fcs;
			res_rem_q     <= emit_rem;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.verdict         = res_verdict_q;
	assign res.ack_required    = res_ack_q;
	assign res.seq_number      = res_seq_q;
	assign res.fcs_is_32       = res_fcs_q;
	assign res.remaining_bytes = res_rem_q;

	// ---------------- assertions ----------------
	a_no_word_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_acc && !rx.frame_start && decided_q) |=> $stable(decided_q) &&
			($stable(res_valid_q) || !res_valid_q))
		else $error("byte outside a frame changed parser or result state");

	a_header_reject_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_verdict_q == VERDICT_BAD_LEN ||
			res_verdict_q == VERDICT_BAD_TYPE || res_verdict_q == VERDICT_BAD_VER))
		|-> (!res_ack_q && res_seq_q == '0 && res_rem_q == '0))
		else $error("header reject carries parsed fields");

	a_emit_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_acc && active && emit) |=> decided_q && res_valid_q)
		else $error("verdict issued without closing the frame");

	a_fcs_needs_sun: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_acc && active && emit && !phy_mode_q) |=> !res_fcs_q)
		else $error("32-bit FCS flagged with one-byte PHR");

endmodule

// ----- bench/frame_header_address_filter_top_tb.sv -----
// ----------------------------------------------------------------------------
// frame_header_address_filter_top_tb - receive frame filter testbench
// Streams frame bytes through the filter under random idling and back
// pressure, predicts each verdict word with an in-bench frame parser and
// compares every field of every verdict in order. Directed frames cover the
// length window, frame control, PAN and address filtering and framing;
// random frames run under several register settings.
// ----------------------------------------------------------------------------
module frame_header_address_filter_top_tb;
	import fhaf_pkg::*;

	localparam logic [2:0] TYPE_DATA = 3'd1;
	localparam logic [2:0] TYPE_CMD  = 3'd3;
	localparam logic [2:0] TYPE_WAKE = 3'd4;
	localparam logic [2:0] TYPE_RSVD = 3'd5;
	localparam logic [2:0] TYPE_TOP  = 3'd7;
	localparam logic [1:0] VER_0     = 2'd0;
	localparam logic [1:0] VER_1     = 2'd1;
	localparam logic [1:0] DM_NONE   = 2'd0;
	localparam logic [1:0] DM_SHORT  = 2'd2;
	localparam logic [1:0] DM_LONG   = 2'd3;
	localparam logic [7:0] PHR_FCS16 = 8'h10;

	typedef struct {
		verdict_t          verdict;
		logic              ack_required;
		logic [BYTE_W-1:0] seq_number;
		logic              fcs_is_32;
		logic [LEN_W-1:0]  remaining_bytes;
	} verdict_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [CFG_W-1:0] pwdata, prdata;

	fhaf_rx_if  rx_ch();
	fhaf_res_if res_ch();

	frame_header_address_filter_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register mirror
	logic [PAN_W-1:0]   cfg_pan_id = 16'hFFFF;
	logic [PAN_W-1:0]   cfg_short  = 16'hFFFE;
	logic [LADDR_W-1:0] cfg_long   = '0;
	logic               cfg_phy    = 1'b0;
	logic [LEN_W-1:0]   cfg_min    = 12'd5;
	logic [LEN_W-1:0]   cfg_max    = 12'd128;
	logic [2:0]         cfg_strobe = 3'd4;

	// parser state
	logic [LEN_W-1:0]   st_pos   = '0;
	logic [LEN_W-1:0]   st_total = '0;
	logic [7:0]         st_phr   = '0;
	logic [7:0]         st_fc_lo = '0;
	logic [7:0]         st_fc_hi = '0;
	logic [7:0]         st_seq   = '0;
	logic [PAN_W-1:0]   st_pan   = '0;
	logic [LADDR_W-1:0] st_addr  = '0;
	bit                 st_done  = 1'b1;

	verdict_word_t expected_verdicts[$];
	logic [7:0]    frame_buf[$];
	int            work_bytes  = 0;
	int            fail_count  = 0;
	int            hold_cycles = 0;
	bit            idle_en     = 1'b1;

	function automatic bit seq_dropped();
		return st_fc_hi[5:4] == VER_2 && st_fc_hi[0];
	endfunction

	function automatic void post_verdict(verdict_t v);
		verdict_word_t w;
		bit parsed, seq_ok;
		parsed = (v == VERDICT_ACCEPT) || (v >= VERDICT_PAN_REJ);
		seq_ok = parsed && !seq_dropped();
		w.verdict = v;
		w.ack_required = seq_ok ? st_fc_lo[ACK_BIT] : 1'b0;
		w.seq_number = seq_ok ? st_seq : 8'd0;
		w.fcs_is_32 = cfg_phy && !st_phr[FCS_BIT];
		w.remaining_bytes = (parsed && st_total >= cfg_min) ? st_total - cfg_min : '0;
		expected_verdicts.push_back(w);
		st_done = 1'b1;
	endfunction

	function automatic void check_length(int unsigned hdr, int unsigned len);
		int unsigned tot;
		tot = hdr + len;
		st_total = LEN_W'(tot);
		if (len == 0 || tot < cfg_min || tot > cfg_max) begin
			post_verdict(VERDICT_BAD_LEN);
		end
	endfunction

	function automatic void filter_byte(logic [7:0] b, logic start);
		int unsigned hdr, p, pstart, k, j;
		logic [15:0] lo16;
		hdr = cfg_phy ? 2 : 1;
		if (start) begin
			st_pos = '0;
			st_total = '0;
			st_phr = '0;
			st_fc_lo = '0;
			st_fc_hi = '0;
			st_seq = '0;
			st_pan = '0;
			st_addr = '0;
			st_done = 1'b0;
		end else if (st_done) begin
			return;
		end
		p = st_pos;
		st_pos = st_pos + 1'b1;
		if (p == 0) begin
			st_phr = b;
			if (hdr == 1) begin
				check_length(hdr, b[6:0]);
			end
			return;
		end
		if (p < hdr) begin
			check_length(hdr, {st_phr[2:0], b});
			return;
		end
		if (p == hdr) begin
			st_fc_lo = b;
			if (b[2:0] > TYPE_MAX && b[2:0] != cfg_strobe) begin
				post_verdict(VERDICT_BAD_TYPE);
			end
			return;
		end
		if (p == hdr + 1) begin
			st_fc_hi = b;
			if (b[5:4] == VER_3) begin
				post_verdict(VERDICT_BAD_VER);
			end else if (seq_dropped() && !st_fc_hi[3]) begin
				post_verdict(VERDICT_ACCEPT);
			end
			return;
		end
		if (!seq_dropped() && p == hdr + 2) begin
			st_seq = b;
			if (!st_fc_hi[3]) begin
				post_verdict(VERDICT_ACCEPT);
			end
			return;
		end
		pstart = hdr + 2 + (seq_dropped() ? 0 : 1);
		if (p < pstart) begin
			return;
		end
		k = p - pstart;
		if (k == 0) begin
			st_pan = {8'h00, b};
			return;
		end
		if (k == 1) begin
			st_pan = st_pan | {b, 8'h00};
			if (st_pan == BCAST16) begin
				if (st_fc_lo[2:0] != TYPE_BEACON) begin
					post_verdict(VERDICT_ACCEPT);
				end
			end else if (cfg_pan_id != BCAST16 && st_pan != cfg_pan_id) begin
				post_verdict(VERDICT_PAN_REJ);
			end
			return;
		end
		j = k - 2;
		if (j < 8) begin
			st_addr = st_addr | (LADDR_W'(b) << (8 * j));
		end
		lo16 = st_addr[15:0];
		if (st_pan == BCAST16) begin
			// beacon: source PAN follows
			if (j == 1) begin
				post_verdict((cfg_pan_id != BCAST16 && cfg_pan_id != lo16) ?
					VERDICT_PAN_REJ : VERDICT_ACCEPT);
			end
			return;
		end
		if (st_fc_hi[3:2] == DM_SHORT) begin
			if (j == 1) begin
				post_verdict((lo16 == BCAST16 || lo16 == cfg_short) ?
					VERDICT_ACCEPT : VERDICT_ADDR_REJ);
			end
			return;
		end
		if (j == 7) begin
			post_verdict(st_addr == cfg_long ? VERDICT_ACCEPT : VERDICT_ADDR_REJ);
		end
	endfunction

	function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
		if (a !== e) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		verdict_word_t w;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: verdict word with none expected, expected none, actual %0d",
					$time, res_ch.verdict);
				fail_count++;
			end else begin
				w = expected_verdicts.pop_front();
				check_field("verdict", w.verdict, res_ch.verdict);
				check_field("ack_required", w.ack_required, res_ch.ack_required);
				check_field("seq_number", w.seq_number, res_ch.seq_number);
				check_field("fcs_is_32", w.fcs_is_32, res_ch.fcs_is_32);
				check_field("remaining_bytes", w.remaining_bytes, res_ch.remaining_bytes);
			end
		end
		if (arst_n && rx_ch.valid && rx_ch.ready) begin
			filter_byte(rx_ch.frame_byte, rx_ch.frame_start);
		end
	end

	// verdict sink: random stall bursts plus long hold-offs on request
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_ch.ready = 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				res_ch.ready = 1'b0;
				stall_left--;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				res_ch.ready = 1'b0;
				stall_left = $urandom_range(1, 16) - 1;
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_byte(logic [7:0] b, logic start);
		int gap;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			rx_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid = 1'b1;
		rx_ch.frame_byte = b;
		rx_ch.frame_start = start;
		do @(posedge clk); while (!rx_ch.ready);
		work_bytes++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		rx_ch.valid = 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		wait_drained();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PAN_ID:     cfg_pan_id = val[15:0];
			REG_SHORT_ADDR: cfg_short = val[15:0];
			REG_LONG_ADDR:  cfg_long = val;
			REG_PHY_MODE:   cfg_phy = val[0];
			REG_MIN_RX:     cfg_min = val[11:0];
			REG_MAX_RX:     cfg_max = val[11:0];
			REG_STROBE:     cfg_strobe = val[2:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic logic [7:0] fcl(logic [2:0] ftype, logic ack);
		return {2'b00, ack, 2'b00, ftype};
	endfunction

	function automatic logic [7:0] fch(logic [1:0] ver, logic [1:0] dm, logic drop);
		return {2'b00, ver, dm, 1'b0, drop};
	endfunction

	function automatic void build_frame(logic [10:0] len, logic [7:0] phr_hi,
			logic [7:0] fc_lo, logic [7:0] fc_hi, logic [7:0] seq, logic [15:0] dpan,
			logic [63:0] daddr, int naddr);
		frame_buf.delete();
		if (cfg_phy) begin
			frame_buf.push_back({phr_hi[7:3], len[10:8]});
			frame_buf.push_back(len[7:0]);
		end else begin
			frame_buf.push_back({phr_hi[7], len[6:0]});
		end
		frame_buf.push_back(fc_lo);
		frame_buf.push_back(fc_hi);
		if (!(fc_hi[5:4] == VER_2 && fc_hi[0])) begin
			frame_buf.push_back(seq);
		end
		frame_buf.push_back(dpan[7:0]);
		frame_buf.push_back(dpan[15:8]);
		for (int i = 0; i < naddr; i++) begin
			frame_buf.push_back(daddr[8*i +: 8]);
		end
	endfunction

	task automatic send_frame(int count);
		int n;
		n = (count < 0 || count > frame_buf.size()) ? frame_buf.size() : count;
		for (int i = 0; i < n; i++) begin
			send_byte(frame_buf[i], i == 0);
		end
	endtask

	task automatic send_header(logic [10:0] len, logic [7:0] phr_hi, logic [7:0] fc_lo,
			logic [7:0] fc_hi, logic [7:0] seq, logic [15:0] dpan, logic [63:0] daddr,
			int naddr);
		build_frame(len, phr_hi, fc_lo, fc_hi, seq, dpan, daddr, naddr);
		send_frame(-1);
	endtask

	task automatic send_random_frame();
		int unsigned hdr, maxlen, lo, hi, len, pick;
		logic [2:0] ftype;
		logic [1:0] ver;
		logic [15:0] dpan;
		logic [63:0] addr;
		hdr = cfg_phy ? 2 : 1;
		maxlen = cfg_phy ? 2047 : 127;
		lo = (cfg_min > hdr + 1) ? cfg_min : hdr + 1;
		hi = (cfg_max < hdr + maxlen) ? cfg_max : hdr + maxlen;
		pick = $urandom_range(0, 9);
		if (pick < 7 && lo <= hi) begin
			len = $urandom_range(lo, hi) - hdr;
		end else if (pick == 9) begin
			len = 0;
		end else begin
			len = $urandom_range(0, maxlen);
		end
		pick = $urandom_range(0, 9);
		ftype = (pick < 6) ? 3'($urandom_range(0, 3)) : (pick < 8) ? cfg_strobe : 3'($urandom);
		ver = ($urandom_range(0, 9) == 0) ? VER_3 : 2'($urandom_range(0, 2));
		pick = $urandom_range(0, 7);
		dpan = (pick < 5) ? cfg_pan_id : (pick < 7) ? BCAST16 : 16'($urandom);
		case ($urandom_range(0, 5))
			0: addr = cfg_long;
			1: addr = cfg_long ^ (64'd1 << $urandom_range(0, 63));
			2: addr = {$urandom, 16'h0000, cfg_short};
			3: addr = {$urandom, 16'h0000, BCAST16};
			4: addr = {$urandom, 16'h0000, cfg_pan_id};
			default: addr = {$urandom, $urandom};
		endcase
		// stray bytes outside a frame
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
		end
		build_frame(11'(len), 8'($urandom), {3'($urandom), 2'($urandom), ftype},
			{2'($urandom), ver, 2'($urandom), 2'($urandom)}, 8'($urandom), dpan, addr, 8);
		repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom));
		// occasionally cut the frame short so the next start abandons it
		send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(1, frame_buf.size() - 1) : -1);
	endtask

	task automatic test_reset_defaults();
		send_header(11'd20, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_1, DM_SHORT, 1'b0), 8'h11,
			16'h1234, 64'hFFFE, 2);
		send_header(11'd9, 8'h80, fcl(TYPE_CMD, 1'b0), fch(VER_0, DM_SHORT, 1'b0), 8'hEE,
			16'hABCD, 64'hFFFF, 2);
		send_header(11'd30, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_1, DM_LONG, 1'b0), 8'h42,
			16'h0001, 64'h0, 8);
	endtask

	task automatic test_length_window();
		send_header(11'd0, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_0, DM_NONE, 1'b0), 8'h01,
			16'h0, 64'h0, 0);
		send_header(11'd3, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_0, DM_NONE, 1'b0), 8'h02,
			16'h0, 64'h0, 0);
		send_header(11'd127, 8'h80, fcl(TYPE_DATA, 1'b1), fch(VER_0, DM_NONE, 1'b0), 8'h7F,
			16'h0, 64'h0, 0);
		write_reg(REG_MAX_RX, 64'd127);
		send_header(11'd127, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_0, DM_NONE, 1'b0), 8'h03,
			16'h0, 64'h0, 0);
		send_header(11'd126, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_0, DM_NONE, 1'b0), 8'h04,
			16'h0, 64'h0, 0);
		// inverted window
		write_reg(REG_MIN_RX, 64'd50);
		write_reg(REG_MAX_RX, 64'd40);
		send_header(11'd45, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_0, DM_NONE, 1'b0), 8'h05,
			16'h0, 64'h0, 0);
		write_reg(REG_PHY_MODE, 64'd1);
		write_reg(REG_MIN_RX, 64'd0);
		write_reg(REG_MAX_RX, 64'd2049);
		send_header(11'd2047, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_0, DM_NONE, 1'b0), 8'h06,
			16'h0, 64'h0, 0);
		send_header(11'd0, PHR_FCS16, fcl(TYPE_DATA, 1'b1), fch(VER_0, DM_NONE, 1'b0), 8'h07,
			16'h0, 64'h0, 0);
		send_header(11'd5, 8'hF8, fcl(TYPE_CMD, 1'b1), fch(VER_1, DM_NONE, 1'b0), 8'h08,
			16'h0, 64'h0, 0);
		write_reg(REG_PHY_MODE, 64'd0);
		write_reg(REG_MIN_RX, 64'd5);
		write_reg(REG_MAX_RX, 64'd128);
	endtask

	task automatic test_frame_control();
		send_header(11'd20, 8'h00, fcl(TYPE_RSVD, 1'b1), fch(VER_0, DM_NONE, 1'b0), 8'h10,
			16'h0, 64'h0, 0);
		send_header(11'd20, 8'h00, fcl(TYPE_WAKE, 1'b1), fch(VER_0, DM_NONE, 1'b0), 8'h11,
			16'h0, 64'h0, 0);
		write_reg(REG_STROBE, 64'd7);
		send_header(11'd20, 8'h00, fcl(TYPE_TOP, 1'b0), fch(VER_0, DM_NONE, 1'b0), 8'h12,
			16'h0, 64'h0, 0);
		send_header(11'd20, 8'h00, fcl(TYPE_WAKE, 1'b1), fch(VER_0, DM_NONE, 1'b0), 8'h13,
			16'h0, 64'h0, 0);
		send_header(11'd20, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_3, DM_SHORT, 1'b0), 8'h14,
			16'h0, 64'h0, 0);
		send_header(11'd20, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_1, DM_NONE, 1'b1), 8'h15,
			16'h0, 64'h0, 0);
		send_header(11'd20, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_2, DM_NONE, 1'b1), 8'h16,
			16'h0, 64'h0, 0);
		send_header(11'd20, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_2, DM_SHORT, 1'b1), 8'h17,
			16'h55AA, 64'hFFFE, 2);
		send_header(11'd20, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_2, DM_SHORT, 1'b0), 8'h18,
			16'h55AA, 64'hFFFE, 2);
	endtask

	task automatic test_address_filter();
		write_reg(REG_PAN_ID, 64'h1234);
		write_reg(REG_SHORT_ADDR, 64'h5678);
		write_reg(REG_LONG_ADDR, 64'h0123_4567_89AB_CDEF);
		send_header(11'd30, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_1, DM_SHORT, 1'b0), 8'h20,
			16'h4321, 64'h5678, 2);
		send_header(11'd30, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_1, DM_SHORT, 1'b0), 8'h21,
			BCAST16, 64'h0, 2);
		send_header(11'd30, 8'h00, fcl(TYPE_BEACON, 1'b0), fch(VER_0, DM_SHORT, 1'b0), 8'h22,
			BCAST16, 64'h1234, 2);
		send_header(11'd30, 8'h00, fcl(TYPE_BEACON, 1'b1), fch(VER_0, DM_SHORT, 1'b0), 8'h23,
			BCAST16, 64'h9999, 2);
		send_header(11'd30, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_1, DM_SHORT, 1'b0), 8'h24,
			16'h1234, 64'h5678, 2);
		send_header(11'd30, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_1, DM_SHORT, 1'b0), 8'h25,
			16'h1234, 64'h5679, 2);
		send_header(11'd30, 8'h00, fcl(TYPE_CMD, 1'b0), fch(VER_1, DM_SHORT, 1'b0), 8'h26,
			16'h1234, 64'hFFFF, 2);
		send_header(11'd30, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_1, DM_LONG, 1'b0), 8'h27,
			16'h1234, 64'h0123_4567_89AB_CDEF, 8);
		send_header(11'd30, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_1, DM_LONG, 1'b0), 8'h28,
			16'h1234, 64'h0023_4567_89AB_CDEF, 8);
	endtask

	task automatic test_framing();
		// bytes after a verdict without a new start are dropped
		repeat (3) send_byte(8'hFF, 1'b0);
		build_frame(11'd30, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_1, DM_SHORT, 1'b0), 8'h30,
			16'h1234, 64'h5679, 2);
		send_frame(4);
		send_header(11'd30, 8'h00, fcl(TYPE_DATA, 1'b1), fch(VER_1, DM_SHORT, 1'b0), 8'h31,
			16'h1234, 64'h5678, 2);
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_cycles = 200;
		for (int i = 0; i < 30; i++) begin
			send_header(11'd10, 8'h00, fcl(TYPE_DATA, i[0]), fch(VER_0, DM_NONE, 1'b0),
				8'(i), 16'h0, 64'h0, 0);
		end
		wait_drained();
	endtask

	task automatic apply_setting(int s);
		case (s)
			0: begin
				write_reg(REG_PAN_ID, 64'($urandom));
				write_reg(REG_SHORT_ADDR, 64'($urandom));
				write_reg(REG_LONG_ADDR, {$urandom, $urandom});
				write_reg(REG_STROBE, 64'd4);
			end
			1: begin
				write_reg(REG_PHY_MODE, 64'd1);
				write_reg(REG_MIN_RX, 64'd0);
				write_reg(REG_MAX_RX, 64'd2049);
				write_reg(REG_PAN_ID, 64'hFFFF);
				write_reg(REG_SHORT_ADDR, 64'hFFFF);
				write_reg(REG_LONG_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
			end
			2: begin
				write_reg(REG_PHY_MODE, 64'd0);
				write_reg(REG_MIN_RX, 64'd60);
				write_reg(REG_MAX_RX, 64'd20);
			end
			3: begin
				write_reg(REG_PHY_MODE, 64'd1);
				write_reg(REG_MIN_RX, 64'd2049);
				write_reg(REG_MAX_RX, 64'd2049);
				write_reg(REG_PAN_ID, 64'd0);
				write_reg(REG_SHORT_ADDR, 64'd0);
				write_reg(REG_LONG_ADDR, 64'd0);
				write_reg(REG_STROBE, 64'd0);
			end
			4: begin
				write_reg(REG_MIN_RX, 64'($urandom_range(3, 40)));
				write_reg(REG_MAX_RX, 64'(cfg_min));
				write_reg(REG_STROBE, 64'($urandom_range(0, 7)));
			end
			default: begin
				write_reg(REG_PHY_MODE, 64'd0);
				write_reg(REG_MIN_RX, 64'd2);
				write_reg(REG_MAX_RX, 64'd100);
				write_reg(REG_PAN_ID, 64'($urandom));
				write_reg(REG_SHORT_ADDR, 64'($urandom));
				write_reg(REG_LONG_ADDR, {$urandom, $urandom});
			end
		endcase
	endtask

	task automatic test_random_traffic();
		int first, quota;
		for (int s = 0; s < 6; s++) begin
			apply_setting(s);
			idle_en = (s != 5);
			quota = 130;
			first = work_bytes;
			while (work_bytes - first < quota) send_random_frame();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.frame_byte = '0;
		rx_ch.frame_start = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_length_window();
		test_frame_control();
		test_address_filter();
		test_framing();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
